FILE: rtl/nrusac_pkg.sv
// Shared constants for the NRU set-associative tag cache.
package nrusac_pkg;

  localparam int unsigned TAG_W       = 32;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned OUT_TDATA_W = 48;
  localparam int unsigned WAY_FIELD_W = 3;
  localparam int unsigned SET_FIELD_W = 6;
  localparam int unsigned MISS_W      = 32;
  localparam int unsigned MAP_FIELDS  = 6;
  localparam int unsigned MAP_FIELD_W = 6;

  localparam int unsigned SETS_DEF            = 64;
  localparam int unsigned WAYS_DEF            = 8;
  localparam int unsigned BLOCK_ADDR_BITS_DEF = 32;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 36;

  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS_USED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BIT_MAP   = 2'd2;

  localparam logic [3:0]            WAYS_IN_USE_RST     = 4'd8;
  localparam logic [2:0]            INDEX_BITS_USED_RST = 3'd6;
  localparam logic [CFG_DATA_W-1:0] INDEX_BIT_MAP_RST   = 36'd5436612672;

  localparam logic [MISS_W-1:0] MISS_MAX = '1;

endpackage

FILE: rtl/nru_set_associative_cache_unit.sv
// Top level of the NRU set-associative tag cache.
//
// Input words arrive on s_axis: tuser is the mode (0 access, 1 flush) and
// tdata carries the block address. Each input word yields exactly one
// result word on m_axis with hit, set number, way and the miss total.
// An access reads one row of the set memory (all ways: tags, valid and NRU
// bits) at acceptance, compares and picks a way in the next cycle, and
// writes the row back at the end of that cycle while loading the result.
// The result word is loaded into the output register when its lookup ends,
// and the block accepts no new word while one is in lookup, since the
// registered read of the set memory is followed by its write-back. A flush
// passes through the same idle and lookup states.
// When m_axis stalls, a waiting result holds in the output register and
// one further word is still accepted; that word holds in its lookup cycle
// until the output register frees up.
// Reset clears all per-set valid flags, the miss total and the config
// registers to their defaults; no clearing pass runs, so the block accepts
// words right after reset. Config writes on cfg_* take effect at once; the
// user must make them only while the block is idle (not enforced).
module nru_set_associative_cache_unit #(
  parameter int unsigned SETS            = nrusac_pkg::SETS_DEF,
  parameter int unsigned WAYS            = nrusac_pkg::WAYS_DEF,
  parameter int unsigned BLOCK_ADDR_BITS = nrusac_pkg::BLOCK_ADDR_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [nrusac_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [nrusac_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [nrusac_pkg::ADDR_W-1:0]        s_axis_tdata,  // [31:0] block_address
  input  logic                                 s_axis_tuser,  // [0] mode
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [0] hit, [6:1] set_number, [9:7] way, [41:10] miss_total, [47:42] zero
  output logic [nrusac_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  localparam int unsigned SetW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WayW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned TagW = nrusac_pkg::TAG_W;
  localparam int unsigned RowW = WAYS * (TagW + 2);
  localparam int unsigned RawSets = 2 ** nrusac_pkg::SET_FIELD_W;

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_LOOKUP = 1'b1;

  typedef struct packed {
    logic             hit;
    logic [WayW-1:0]  way;
    logic             alloc;
  } pick_t;

  // Config registers
  logic [3:0]                          ways_q;
  logic [2:0]                          ibits_q;
  logic [nrusac_pkg::CFG_DATA_W-1:0]   imap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ways_q  <= nrusac_pkg::WAYS_IN_USE_RST;
      ibits_q <= nrusac_pkg::INDEX_BITS_USED_RST;
      imap_q  <= nrusac_pkg::INDEX_BIT_MAP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nrusac_pkg::CFG_WAYS_IN_USE:     ways_q  <= cfg_wdata_i[3:0];
        nrusac_pkg::CFG_INDEX_BITS_USED: ibits_q <= cfg_wdata_i[2:0];
        nrusac_pkg::CFG_INDEX_BIT_MAP:   imap_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Set selection
  logic [2:0]                            bits_n;
  logic [nrusac_pkg::SET_FIELD_W-1:0]    raw_set;
  logic [SetW-1:0]                       set_lut [RawSets];
  logic [SetW-1:0]                       set_sel;

  always_comb begin
    logic [nrusac_pkg::MAP_FIELD_W-1:0] pos;
    bits_n  = (ibits_q > 3'd6) ? 3'd6 : ibits_q;
    raw_set = '0;
    for (int j = 0; j < nrusac_pkg::MAP_FIELDS; j++) begin
      pos = imap_q[j*nrusac_pkg::MAP_FIELD_W +: nrusac_pkg::MAP_FIELD_W];
      if ((3'(j) < bits_n) && ({1'b0, pos} < 7'(BLOCK_ADDR_BITS)) && !pos[5]) begin
        raw_set[j] = s_axis_tdata[pos[4:0]];
      end
    end
  end

  for (genvar g = 0; g < RawSets; g++) begin : g_set_lut
    localparam int unsigned SetMod = g % SETS;
    assign set_lut[g] = SetW'(SetMod);
  end

  assign set_sel = set_lut[raw_set];

  // Control and item registers
  logic                          state_q, state_d;
  logic                          flush_q;
  logic [TagW-1:0]               addr_q;
  logic [SetW-1:0]               set_q;
  logic [SETS-1:0]               row_vld_q, row_vld_d;
  logic [nrusac_pkg::MISS_W-1:0] miss_q, miss_d;
  logic                          out_vld_q, out_vld_d;
  logic                          out_hit_q;
  logic [SetW-1:0]               out_set_q;
  logic [WayW-1:0]               out_way_q;
  logic [nrusac_pkg::MISS_W-1:0] out_miss_q;

  logic accept;
  logic done;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign done          = (state_q == ST_LOOKUP) && (!out_vld_q || m_axis_tready);

  // Set memory
  logic            ram_we;
  logic [RowW-1:0] ram_rdata;
  logic [RowW-1:0] ram_wdata;

  nrusac_ram #(
    .WIDTH (RowW),
    .DEPTH (SETS)
  ) u_set_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (set_q),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (set_sel),
    .rdata_o (ram_rdata)
  );

  // Lookup and way selection
  logic [4:0]      ways_n;
  logic [WAYS-1:0] in_use;
  logic [WAYS-1:0] vld_eff, nru_eff;
  logic [WAYS-1:0] hit_vec, nru_vec;
  logic [WAYS-1:0] vld_new, nru_new;
  logic [TagW-1:0] tag_rd [WAYS];
  logic [TagW-1:0] tag_new [WAYS];
  logic            row_vld;
  pick_t           pick;

  always_comb begin
    ways_n = (ways_q == 4'd0) ? 5'd1 :
             (({1'b0, ways_q} > 5'(WAYS)) ? 5'(WAYS) : {1'b0, ways_q});
    row_vld = row_vld_q[set_q];
    vld_eff = row_vld ? ram_rdata[WAYS*TagW +: WAYS] : '0;
    nru_eff = row_vld ? ram_rdata[WAYS*TagW + WAYS +: WAYS] : '1;
    for (int w = 0; w < WAYS; w++) begin
      in_use[w]  = (5'(w) < ways_n);
      tag_rd[w]  = ram_rdata[w*TagW +: TagW];
      hit_vec[w] = in_use[w] && vld_eff[w] && (tag_rd[w] == addr_q);
      nru_vec[w] = in_use[w] && nru_eff[w];
    end
  end

  always_comb begin
    pick.hit   = |hit_vec;
    pick.alloc = |nru_vec;
    pick.way   = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (pick.hit ? hit_vec[w] : nru_vec[w]) begin
        pick.way = WayW'(w);
      end
    end
  end

  always_comb begin
    vld_new = vld_eff;
    nru_new = nru_eff;
    for (int w = 0; w < WAYS; w++) begin
      tag_new[w] = tag_rd[w];
    end
    if (!pick.hit) begin
      if (!pick.alloc) begin
        nru_new = nru_eff | in_use;
      end
      tag_new[pick.way] = addr_q;
      vld_new[pick.way] = 1'b1;
    end
    nru_new[pick.way] = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      ram_wdata[w*TagW +: TagW] = tag_new[w];
    end
    ram_wdata[WAYS*TagW +: WAYS]        = vld_new;
    ram_wdata[WAYS*TagW + WAYS +: WAYS] = nru_new;
  end

  assign ram_we = done && !flush_q;

  // Next state
  always_comb begin
    state_d   = state_q;
    row_vld_d = row_vld_q;
    miss_d    = miss_q;
    out_vld_d = out_vld_q && !m_axis_tready;
    if (accept) begin
      state_d = ST_LOOKUP;
    end
    if (done) begin
      state_d   = ST_IDLE;
      out_vld_d = 1'b1;
      if (flush_q) begin
        row_vld_d = '0;
        miss_d    = '0;
      end else begin
        row_vld_d[set_q] = 1'b1;
        if (!pick.hit && (miss_q != nrusac_pkg::MISS_MAX)) begin
          miss_d = miss_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      row_vld_q <= '0;
      miss_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      row_vld_q <= row_vld_d;
      miss_q    <= miss_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      flush_q <= s_axis_tuser;
      addr_q  <= s_axis_tdata;
      set_q   <= set_sel;
    end
    if (done) begin
      out_hit_q  <= !flush_q && pick.hit;
      out_set_q  <= flush_q ? '0 : set_q;
      out_way_q  <= flush_q ? '0 : pick.way;
      out_miss_q <= miss_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0,
                          out_miss_q,
                          nrusac_pkg::WAY_FIELD_W'(out_way_q),
                          nrusac_pkg::SET_FIELD_W'(out_set_q),
                          out_hit_q};

  // Assertions
  a_accept_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_LOOKUP))
    else $error("accepted word did not enter lookup");

  a_wb_only_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((state_q == ST_LOOKUP) && !flush_q && done))
    else $error("set memory written outside an access write-back");

  a_miss_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && !flush_q) |=> (miss_q >= $past(miss_q)))
    else $error("miss total decreased without flush");

  a_result_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> m_axis_tvalid)
    else $error("lookup finished without a result");

endmodule

FILE: rtl/nrusac_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module nrusac_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
